>>> src/ctc_pkg.sv
// Shared types and constants for the C-like token classifier.
package ctc_pkg;

	// Scanner mode kept between bytes.
	typedef enum logic [3:0] {
		M_IDLE       = 4'd0,
		M_IDENT      = 4'd1,
		M_NUMBER     = 4'd2,
		M_STR        = 4'd3,
		M_STR_ESC    = 4'd4,
		M_CHAR_OPEN  = 4'd5,
		M_CHAR_ESC   = 4'd6,
		M_CHAR_CLOSE = 4'd7,
		M_OP1        = 4'd8
	} lex_mode_t;

	// Token class carried with every tagged byte.
	typedef enum logic [3:0] {
		K_IDENT   = 4'd0,
		K_NUMBER  = 4'd1,
		K_STRING  = 4'd2,
		K_CHAR    = 4'd3,
		K_OPER    = 4'd4,
		K_PUNCT   = 4'd5,
		K_NEWLINE = 4'd6,
		K_UNKNOWN = 4'd7,
		K_SPACE   = 4'd8
	} kind_t;

	// One source byte.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       source_end;
	} src_item_t;

	// One tagged byte.
	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      token_kind;
		logic       token_first;
		logic       token_last;
		logic       in_text;
		logic       run_last;
		logic       stream_done;
	} tag_item_t;

	// Classification of one byte in the current mode.
	typedef struct packed {
		kind_t     kind;
		logic      first;
		logic      text;
		lex_mode_t next_mode;
	} tag_info_t;

	// Result queue sizing.
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

endpackage

>>> src/ctc_classify.sv
// Byte classifier: token class, start mark, text mark and next scanner mode.
module ctc_classify (
	input  ctc_pkg::lex_mode_t mode,
	input  logic [7:0]         data_byte,
	output ctc_pkg::tag_info_t info
);
	import ctc_pkg::*;

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_word(input logic [7:0] b);
		return is_alpha(b) || is_digit(b) || b == "_";
	endfunction

	// Space, tab, vertical tab, form feed and carriage return.
	function automatic logic is_blank(input logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D && b != 8'h0A);
	endfunction

	function automatic logic is_op(input logic [7:0] b);
		return b == "+" || b == "-" || b == "*" || b == "/" || b == "=" || b == "%" ||
			b == "!" || b == "<" || b == ">" || b == "|" || b == "&" || b == "^";
	endfunction

	function automatic logic is_delim(input logic [7:0] b);
		return b == "(" || b == ")" || b == "{" || b == "}" || b == "," || b == "." ||
			b == ";" || b == "[" || b == "]";
	endfunction

	function automatic tag_info_t mk(input kind_t k, input logic f, input logic t,
			input lex_mode_t m);
		tag_info_t r;
		r.kind      = k;
		r.first     = f;
		r.text      = t;
		r.next_mode = m;
		return r;
	endfunction

	// Classification of a byte that opens a new token.
	function automatic tag_info_t start_token(input logic [7:0] b);
		tag_info_t r;
		if (b == 8'h0A) begin
			r = mk(K_NEWLINE, 1'b1, 1'b1, M_IDLE);
		end else if (is_blank(b)) begin
			r = mk(K_SPACE, 1'b0, 1'b0, M_IDLE);
		end else if (is_alpha(b) || b == "_") begin
			r = mk(K_IDENT, 1'b1, 1'b1, M_IDENT);
		end else if (is_digit(b)) begin
			r = mk(K_NUMBER, 1'b1, 1'b1, M_NUMBER);
		end else if (b == 8'h22) begin
			r = mk(K_STRING, 1'b1, 1'b0, M_STR);
		end else if (b == 8'h27) begin
			r = mk(K_CHAR, 1'b1, 1'b0, M_CHAR_OPEN);
		end else if (is_op(b)) begin
			r = mk(K_OPER, 1'b1, 1'b1, M_OP1);
		end else if (is_delim(b)) begin
			r = mk(K_PUNCT, 1'b1, 1'b1, M_IDLE);
		end else begin
			r = mk(K_UNKNOWN, 1'b1, 1'b1, M_IDLE);
		end
		return r;
	endfunction

	always_comb begin
		unique case (mode)
			M_IDENT: begin
				info = is_word(data_byte) ? mk(K_IDENT, 1'b0, 1'b1, M_IDENT)
					: start_token(data_byte);
			end
			M_NUMBER: begin
				info = (is_digit(data_byte) || data_byte == ".")
					? mk(K_NUMBER, 1'b0, 1'b1, M_NUMBER) : start_token(data_byte);
			end
			M_STR: begin
				if (data_byte == 8'h22) begin
					info = mk(K_STRING, 1'b0, 1'b0, M_IDLE);
				end else if (data_byte == 8'h5C) begin
					info = mk(K_STRING, 1'b0, 1'b1, M_STR_ESC);
				end else begin
					info = mk(K_STRING, 1'b0, 1'b1, M_STR);
				end
			end
			M_STR_ESC: begin
				info = mk(K_STRING, 1'b0, 1'b1, M_STR);
			end
			M_CHAR_OPEN: begin
				info = mk(K_CHAR, 1'b0, 1'b1,
					(data_byte == 8'h5C) ? M_CHAR_ESC : M_CHAR_CLOSE);
			end
			M_CHAR_ESC: begin
				info = mk(K_CHAR, 1'b0, 1'b1, M_CHAR_CLOSE);
			end
			M_CHAR_CLOSE: begin
				info = (data_byte == 8'h27) ? mk(K_CHAR, 1'b0, 1'b0, M_IDLE)
					: start_token(data_byte);
			end
			M_OP1: begin
				info = is_op(data_byte) ? mk(K_OPER, 1'b0, 1'b1, M_IDLE)
					: start_token(data_byte);
			end
			default: begin
				info = start_token(data_byte);
			end
		endcase
	end

endmodule

>>> src/ctc_out_fifo.sv
// Result queue that takes up to two tagged bytes per cycle and gives one per cycle while tag_ready is high.
module ctc_out_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_n,
	input  ctc_pkg::tag_item_t wr_a,
	input  ctc_pkg::tag_item_t wr_b,
	output logic               room2,
	output logic               tag_valid,
	input  logic               tag_ready,
	output ctc_pkg::tag_item_t tag_data
);
	import ctc_pkg::*;

	tag_item_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               pop;

	assign tag_valid = cnt_q != '0;
	assign pop       = tag_valid && tag_ready;
	assign tag_data  = mem_q[rd_ptr_q];
	assign room2     = cnt_q <= QCNT_W'(QDEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_ptr_q] <= wr_a;
		end
		if (push_n == 2'd2) begin
			mem_q[QPTR_W'(wr_ptr_q + 1'b1)] <= wr_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= QPTR_W'(wr_ptr_q + QPTR_W'(push_n));
			rd_ptr_q <= QPTR_W'(rd_ptr_q + QPTR_W'(pop));
			cnt_q    <= QCNT_W'(cnt_q + QCNT_W'(push_n) - QCNT_W'(pop));
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue count out of range");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push_n == 2'd0 |=> cnt_q == QCNT_W'($past(cnt_q) - 1'b1))
		else $error("result queue count did not drop on a pop");

	a_push_two: assert property (@(posedge clk) disable iff (!arst_n)
		!pop && push_n == 2'd2 |=> cnt_q == QCNT_W'($past(cnt_q) + 2'd2))
		else $error("result queue count did not rise by two");
`endif

endmodule

>>> src/c_like_token_classifier.sv
// Top level of the C-like token classifier: scanner state, tagging and result queue.
//
// Source text enters one byte per transaction on the src channel (src_valid,
// src_ready, src_data), with source_end set on the final byte. Every byte
// comes back on the tag channel (tag_valid, tag_ready, tag_data), tagged with
// its token class, token start and end marks and whether it is token text.
// A byte is held until the next byte is seen, since only then is it known
// whether the byte ends its token; so a byte's result enters the result queue
// when the following byte is accepted, and is offered on the tag channel
// from the registered queue. The final byte of a source releases the held
// byte, if any, and the final byte itself at once, the latter with stream_done set.
// A new byte can be accepted in every cycle while src_ready is high; sustained
// throughput is one byte per cycle while the receiver keeps up, limited by the
// single read port of the four-entry result queue. src_ready drops only while
// the queue lacks room for two results, as on a receiver stall on the tag channel.
// Reset clears the scanner to idle between tokens, drops any held byte and
// empties the result queue. After a final byte the scanner starts a new
// source from idle.
module c_like_token_classifier (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  ctc_pkg::src_item_t src_data,
	output logic               tag_valid,
	input  logic               tag_ready,
	output ctc_pkg::tag_item_t tag_data
);
	import ctc_pkg::*;

	// Scanner state and the byte waiting for its lookahead.
	lex_mode_t  mode_q;
	logic       held_valid_q;
	logic [7:0] held_byte_q;
	kind_t      held_kind_q;
	logic       held_first_q;
	logic       held_in_text_q;

	tag_info_t  info;
	logic       accept;
	logic       last_byte;
	logic       continues;
	logic       room2;
	logic [1:0] push_n;
	tag_item_t  held_item;
	tag_item_t  end_item;
	tag_item_t  wr_a;

	ctc_classify u_classify (
		.mode      (mode_q),
		.data_byte (src_data.data_byte),
		.info      (info)
	);

	assign src_ready = room2;
	assign accept    = src_valid && src_ready;
	assign last_byte = src_data.source_end;

	// The new byte extends the held byte's token when it is neither a token
	// start nor whitespace; otherwise the held byte closes its token.
	assign continues = !info.first && info.kind != K_SPACE;

	always_comb begin
		held_item.out_byte    = held_byte_q;
		held_item.token_kind  = held_kind_q;
		held_item.token_first = held_first_q;
		held_item.token_last  = held_kind_q != K_SPACE && !continues;
		held_item.in_text     = held_in_text_q;
		held_item.run_last    = !last_byte;
		held_item.stream_done = 1'b0;

		// On the final byte, the byte itself closes whatever token it is in.
		end_item.out_byte    = src_data.data_byte;
		end_item.token_kind  = info.kind;
		end_item.token_first = info.first;
		end_item.token_last  = info.kind != K_SPACE;
		end_item.in_text     = info.text;
		end_item.run_last    = 1'b1;
		end_item.stream_done = 1'b1;
	end

	// The held byte always goes first; the final byte follows it, or goes
	// alone when nothing is held.
	assign wr_a   = held_valid_q ? held_item : end_item;
	assign push_n = accept ? (2'(held_valid_q) + 2'(last_byte)) : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= M_IDLE;
			held_valid_q   <= 1'b0;
			held_byte_q    <= '0;
			held_kind_q    <= K_IDENT;
			held_first_q   <= 1'b0;
			held_in_text_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				mode_q         <= M_IDLE;
				held_valid_q   <= 1'b0;
				held_byte_q    <= '0;
				held_kind_q    <= K_IDENT;
				held_first_q   <= 1'b0;
				held_in_text_q <= 1'b0;
			end else begin
				mode_q         <= info.next_mode;
				held_valid_q   <= 1'b1;
				held_byte_q    <= src_data.data_byte;
				held_kind_q    <= info.kind;
				held_first_q   <= info.first;
				held_in_text_q <= info.text;
			end
		end
	end

	ctc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.wr_a      (wr_a),
		.wr_b      (end_item),
		.room2     (room2),
		.tag_valid (tag_valid),
		.tag_ready (tag_ready),
		.tag_data  (tag_data)
	);

`ifndef SYNTH
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_byte |=> !held_valid_q && mode_q == M_IDLE)
		else $error("scanner not idle after the final byte");

	a_byte_held: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last_byte |=> held_valid_q)
		else $error("accepted byte was not held");

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid && tag_data.stream_done |-> tag_data.run_last)
		else $error("stream end result does not close its run");
`endif

endmodule
